/* rtl/bbcm_pkg.sv */
// shared types and codes for the block buffer cache manager
// no dependencies
package bbcm_pkg;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_MARK_WR = 2'd1,
    OP_RELEASE = 2'd2,
    OP_IO_DONE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUSY     = 2'd1,
    ST_NO_BUF   = 2'd2,
    ST_NOT_HELD = 2'd3
  } status_e;

  localparam logic [7:0] NO_DEVICE = 8'hFF;
  localparam int unsigned TAG_W = 40;

endpackage

/* rtl/bbcm_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module bbcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/block_buffer_cache_manager.sv */
// block buffer cache manager: tags and recency ranks in two rams, marks in flops
// depends on bbcm_pkg and bbcm_ram
// mark write and io done answer straight from idle; get scans the tag and rank rams;
// release reads the slot's rank, then sweeps the rank ram read-modify-write. one item at a time,
// next item taken once the result has been delivered. reset is asynchronous, active low:
// all marks cleared, never-written ram entries read as reset tag and initial rank.
module block_buffer_cache_manager #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [7:0]                   device_i,
  input  logic [31:0]                  block_number_i,
  input  logic [3:0]                   slot_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [3:0]                   slot_out_o,
  output logic                         need_read_o,
  output logic                         need_write_o
);
  import bbcm_pkg::*;

  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = IW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_REL_RD, S_REL_OLD, S_SWEEP
  } state_e;

  state_e state_q, state_d;

  // per-slot marks and ram-written flags
  logic [SLOT_COUNT-1:0] busy_q, busy_d, valid_q, valid_d, dirty_q, dirty_d;
  logic [SLOT_COUNT-1:0] tw_q, tw_d, rw_q, rw_d;

  // request registers
  logic [7:0]    dev_q, dev_d;
  logic [31:0]   blk_q, blk_d;
  logic [IW-1:0] s_q, s_d;

  // scan pipeline
  logic [CW-1:0] cnt_q, cnt_d;
  logic          p_valid_q, p_valid_d;
  logic [IW-1:0] p_idx_q, p_idx_d;

  // scan results
  logic          hit_q, hit_d, vic_q, vic_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d, vic_idx_q, vic_idx_d;
  logic [IW-1:0] hit_rank_q, hit_rank_d, vic_rank_q, vic_rank_d, old_q, old_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [3:0] slot_out_q, slot_out_d;
  logic       nr_q, nr_d, nw_q, nw_d;

  // ram ports
  logic              tag_we, rank_we;
  logic [IW-1:0]     tag_waddr, rank_waddr, raddr;
  logic [TAG_W-1:0]  tag_wdata, tag_rdata, tag_rd;
  logic [IW-1:0]     rank_wdata, rank_rdata, rank_rd;

  logic          accept, in_range;
  logic [IW-1:0] sidx;

  bbcm_ram #(.Width(TAG_W), .Depth(SLOT_COUNT)) u_tag_ram (
    .clk_i, .we_i(tag_we), .waddr_i(tag_waddr), .wdata_i(tag_wdata),
    .raddr_i(raddr), .rdata_o(tag_rdata)
  );

  bbcm_ram #(.Width(IW), .Depth(SLOT_COUNT)) u_rank_ram (
    .clk_i, .we_i(rank_we), .waddr_i(rank_waddr), .wdata_i(rank_wdata),
    .raddr_i(raddr), .rdata_o(rank_rdata)
  );

  assign in_stall_o   = (state_q != S_IDLE) || out_valid_q;
  assign accept       = in_valid_i && !in_stall_o;
  assign in_range     = (32'(slot_i) < SLOT_COUNT);
  assign sidx         = IW'(32'(slot_i));
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_out_o   = slot_out_q;
  assign need_read_o  = nr_q;
  assign need_write_o = nw_q;

  // entries never written read as their reset value
  assign tag_rd  = tw_q[p_idx_q] ? tag_rdata : {NO_DEVICE, 32'd0};
  assign rank_rd = rw_q[p_idx_q] ? rank_rdata : (IW'(SLOT_COUNT - 1) - p_idx_q);

  always_comb begin
    state_d = state_q;
    busy_d = busy_q; valid_d = valid_q; dirty_d = dirty_q;
    tw_d = tw_q; rw_d = rw_q;
    dev_d = dev_q; blk_d = blk_q; s_d = s_q;
    cnt_d = cnt_q; p_valid_d = 1'b0; p_idx_d = p_idx_q;
    hit_d = hit_q; vic_d = vic_q; hit_idx_d = hit_idx_q; vic_idx_d = vic_idx_q;
    hit_rank_d = hit_rank_q; vic_rank_d = vic_rank_q; old_d = old_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d = status_q; slot_out_d = slot_out_q; nr_d = nr_q; nw_d = nw_q;
    tag_we = 1'b0; tag_waddr = vic_idx_q; tag_wdata = {dev_q, blk_q};
    rank_we = 1'b0; rank_waddr = p_idx_q; rank_wdata = '0;
    raddr = cnt_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          dev_d = device_i; blk_d = block_number_i; s_d = sidx;
          status_d = ST_OK; slot_out_d = slot_i; nr_d = 1'b0; nw_d = 1'b0;
          if (opcode_i == OP_GET) begin
            cnt_d = '0; hit_d = 1'b0; vic_d = 1'b0;
            state_d = S_SCAN;
          end else if (!in_range || !busy_q[sidx]) begin
            status_d = ST_NOT_HELD; out_valid_d = 1'b1;
          end else begin
            case (opcode_e'(opcode_i))
              OP_MARK_WR: begin
                dirty_d[sidx] = 1'b1; nw_d = 1'b1; out_valid_d = 1'b1;
              end
              OP_IO_DONE: begin
                valid_d[sidx] = 1'b1; dirty_d[sidx] = 1'b0; out_valid_d = 1'b1;
              end
              default: begin
                busy_d[sidx] = 1'b0;
                raddr = sidx; p_idx_d = sidx;
                state_d = S_REL_RD;
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        if (cnt_q < CW'(SLOT_COUNT)) begin
          raddr = cnt_q[IW-1:0];
          p_valid_d = 1'b1; p_idx_d = cnt_q[IW-1:0]; cnt_d = cnt_q + 1'b1;
        end
        if (p_valid_q) begin
          if (tag_rd == {dev_q, blk_q} && (!hit_q || rank_rd > hit_rank_q)) begin
            hit_d = 1'b1; hit_idx_d = p_idx_q; hit_rank_d = rank_rd;
          end
          if (!busy_q[p_idx_q] && !dirty_q[p_idx_q] && (!vic_q || rank_rd > vic_rank_q)) begin
            vic_d = 1'b1; vic_idx_d = p_idx_q; vic_rank_d = rank_rd;
          end
        end else if (cnt_q == CW'(SLOT_COUNT)) begin
          // scan done: decide
          out_valid_d = 1'b1; state_d = S_IDLE;
          if (hit_q) begin
            slot_out_d = 4'(32'(hit_idx_q));
            if (busy_q[hit_idx_q]) begin
              status_d = ST_BUSY;
            end else begin
              busy_d[hit_idx_q] = 1'b1; nr_d = !valid_q[hit_idx_q];
            end
          end else if (vic_q) begin
            tag_we = 1'b1; tw_d[vic_idx_q] = 1'b1;
            busy_d[vic_idx_q] = 1'b1; valid_d[vic_idx_q] = 1'b0;
            dirty_d[vic_idx_q] = 1'b0;
            slot_out_d = 4'(32'(vic_idx_q)); nr_d = 1'b1;
          end else begin
            status_d = ST_NO_BUF; slot_out_d = 4'd0;
          end
        end
      end
      S_REL_RD: begin
        // keep the released slot's rank on the read port
        raddr = s_q;
        state_d = S_REL_OLD;
      end
      S_REL_OLD: begin
        old_d = rank_rd; cnt_d = '0; state_d = S_SWEEP;
      end
      S_SWEEP: begin
        if (cnt_q < CW'(SLOT_COUNT)) begin
          raddr = cnt_q[IW-1:0];
          p_valid_d = 1'b1; p_idx_d = cnt_q[IW-1:0]; cnt_d = cnt_q + 1'b1;
        end
        if (p_valid_q) begin
          rank_we = 1'b1; rw_d[p_idx_q] = 1'b1;
          if (p_idx_q == s_q) rank_wdata = '0;
          else if (rank_rd < old_q) rank_wdata = rank_rd + 1'b1;
          else rank_wdata = rank_rd;
        end else if (cnt_q == CW'(SLOT_COUNT)) begin
          out_valid_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q <= '0; valid_q <= '0; dirty_q <= '0; tw_q <= '0; rw_q <= '0;
      p_valid_q <= 1'b0; out_valid_q <= 1'b0;
      cnt_q <= '0; hit_q <= 1'b0; vic_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q <= busy_d; valid_q <= valid_d; dirty_q <= dirty_d;
      tw_q <= tw_d; rw_q <= rw_d;
      p_valid_q <= p_valid_d; out_valid_q <= out_valid_d;
      cnt_q <= cnt_d; hit_q <= hit_d; vic_q <= vic_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dev_q <= dev_d; blk_q <= blk_d; s_q <= s_d; p_idx_q <= p_idx_d;
    hit_idx_q <= hit_idx_d; vic_idx_q <= vic_idx_d;
    hit_rank_q <= hit_rank_d; vic_rank_q <= vic_rank_d; old_q <= old_d;
    status_q <= status_d; slot_out_q <= slot_out_d; nr_q <= nr_d; nw_q <= nw_d;
  end

  a_rank_wr_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_we |-> state_q == S_SWEEP) else $error("rank write outside sweep");
  a_tag_wr_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_we |-> (state_q == S_SCAN && !hit_q && vic_q)) else $error("bad tag write");
  a_busy_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !out_valid_q) |-> !in_stall_o) else $error("idle but stalled");
  a_pipe_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (state_q == S_SCAN || state_q == S_SWEEP)) else $error("stray pipe");
endmodule
